// ===== src/saturating_audio_mix_accumulator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the audio mix accumulator
// Concurrent checks sampled on the rising clock edge, masked during reset.
// ----------------------------------------------------------------------------
`ifndef SATURATING_AUDIO_MIX_ACCUMULATOR_UNIT_DEFINES_SVH
`define SATURATING_AUDIO_MIX_ACCUMULATOR_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SAMACC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle.
`define SAMACC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/samacc_pkg.sv =====
// ----------------------------------------------------------------------------
// samacc_pkg
// Shared constants, field layout and controller/datapath interface types.
// ----------------------------------------------------------------------------
package samacc_pkg;

   // configuration defaults
   localparam int MAX_FRAMES_DEF = 4096;
   localparam int CHANNELS_DEF   = 2;

   // field widths
   localparam int WIN_W     = 13;
   localparam int OFFSET_W  = 13;
   localparam int SAMPLE_W  = 24;
   localparam int GAIN_W    = 10;
   localparam int MIX_W     = 16;

   localparam logic [WIN_W-1:0] WIN_RESET = 13'd4096;

   // request beat layout in tdata
   localparam int REQ_DATA_W = 64;
   localparam int OFF_LSB    = 0;
   localparam int CH_BIT     = 13;
   localparam int SMP_LSB    = 14;
   localparam int PRES_BIT   = 38;
   localparam int SG_LSB     = 39;
   localparam int UGV_BIT    = 49;
   localparam int UG_LSB     = 50;

   // request kind on tuser
   localparam logic REQ_ACCUM = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   // scaling arithmetic
   localparam int GAIN2_W     = 2 * GAIN_W;
   localparam int PROD_W      = SAMPLE_W + GAIN2_W;
   localparam int SCALE_SHIFT = 15;          // full scale 32767 = 2^15 - 1
   localparam int SCALED_W    = PROD_W + SCALE_SHIFT;
   localparam int Q_FRAC      = 23;
   localparam int DVD_W       = SCALED_W - Q_FRAC;
   localparam int DEN_W       = 14;
   localparam logic [DEN_W-1:0] PCT_DEN  = 14'd100;
   localparam logic [DEN_W-1:0] PCT2_DEN = 14'd10000;

   localparam logic [MIX_W-1:0] MIX_MAX = 16'h7FFF;
   localparam logic [MIX_W-1:0] MIX_MIN = 16'h8000;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic mul_gain;
      logic mul_sample;
      logic scale;
      logic div_start;
      logic acc_write;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic drain;
      logic work;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

// ===== src/samacc_div.sv =====
// ----------------------------------------------------------------------------
// samacc_div
// Percent scaling divider: registered reciprocal multiply, result held
// saturated to 16 bits.
// ----------------------------------------------------------------------------
module samacc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [samacc_pkg::DVD_W-1:0] dividend,
   input  logic                         two_gains,
   output logic [samacc_pkg::MIX_W-1:0] quotient,
   output logic                         done
);

   localparam int DW  = samacc_pkg::DVD_W;
   localparam int MW  = samacc_pkg::MIX_W;
   localparam int XW  = 30;             // dividend bits below either limit
   localparam int RW  = 31;
   localparam int PW  = XW + RW;
   localparam int SH1 = 30;
   localparam int SH2 = 44;
   // ceil(2^30 / 100) and ceil(2^44 / 10000), exact below the limits
   localparam logic [RW-1:0] RECIP1 = RW'(10737419);
   localparam logic [RW-1:0] RECIP2 = RW'(1759218605);
   // 65536 times the divisor: quotients from here on saturate
   localparam logic [DW-1:0] LIMIT1 = DW'(6553600);
   localparam logic [DW-1:0] LIMIT2 = DW'(655360000);

   logic [DW-1:0] dvd_ff, dvd_in;
   logic          sel_ff, sel_in;
   logic          step_ff, step_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic          over_ff, over_in;
   logic          done_ff, done_in;

   logic [RW-1:0] recip;
   logic [DW-1:0] limit;

   assign recip = sel_ff ? RECIP2 : RECIP1;
   assign limit = sel_ff ? LIMIT2 : LIMIT1;

   always_comb begin
      dvd_in  = dvd_ff;
      sel_in  = sel_ff;
      prod_in = prod_ff;
      over_in = over_ff;
      step_in = 1'b0;
      done_in = done_ff;
      if (start) begin
         dvd_in  = dividend;
         sel_in  = two_gains;
         step_in = 1'b1;
         done_in = 1'b0;
      end else if (step_ff) begin
         prod_in = PW'(dvd_ff[XW-1:0]) * PW'(recip);
         over_in = dvd_ff >= limit;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      sel_ff  <= sel_in;
      prod_ff <= prod_in;
      over_ff <= over_in;
      if (reset) begin
         step_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   assign quotient = over_ff ? {MW{1'b1}}
                             : (sel_ff ? prod_ff[SH2 +: MW] : prod_ff[SH1 +: MW]);
   assign done     = done_ff;

endmodule

// ===== src/samacc_dp.sv =====
// ----------------------------------------------------------------------------
// samacc_dp
// Datapath: request capture, gain scaling, mix store and response register.
// ----------------------------------------------------------------------------
`include "saturating_audio_mix_accumulator_unit_defines.svh"

module samacc_dp #(
   parameter int MAX_FRAMES = samacc_pkg::MAX_FRAMES_DEF,
   parameter int CHANNELS   = samacc_pkg::CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [samacc_pkg::WIN_W-1:0]      csr_wr_data,
   input  logic [samacc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [samacc_pkg::MIX_W-1:0]      rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  samacc_pkg::ctrl_cmd_type          cmd,
   output samacc_pkg::dp_status_type         status
);

   localparam int DEPTH = MAX_FRAMES * CHANNELS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   localparam int OW  = samacc_pkg::OFFSET_W;
   localparam int SW  = samacc_pkg::SAMPLE_W;
   localparam int GW  = samacc_pkg::GAIN_W;
   localparam int G2W = samacc_pkg::GAIN2_W;
   localparam int PW  = samacc_pkg::PROD_W;
   localparam int SH  = samacc_pkg::SCALE_SHIFT;
   localparam int XW  = samacc_pkg::SCALED_W;
   localparam int MW  = samacc_pkg::MIX_W;
   localparam int ACW = MW + 2;

   // ---------------------------------------------------------------- request
   logic [OW-1:0] off;
   logic          ch;
   logic [SW-1:0] smp;
   logic [31:0]   idx_wide;
   logic          hit_req;

   assign off = req_tdata[samacc_pkg::OFF_LSB +: OW];
   assign ch  = req_tdata[samacc_pkg::CH_BIT];
   assign smp = req_tdata[samacc_pkg::SMP_LSB +: SW];

   logic [samacc_pkg::WIN_W-1:0] window_ff, window_in;

   assign hit_req = !off[OW-1]
                    && ({1'b0, off[OW-2:0]} < window_ff)
                    && (32'(off[OW-2:0]) < MAX_FRAMES)
                    && (32'(ch) < CHANNELS);
   assign idx_wide = 32'(off[OW-2:0]) * 32'(CHANNELS) + 32'(ch);

   logic          drain_ff, drain_in;
   logic          last_ff, last_in;
   logic          hit_ff, hit_in;
   logic          present_ff, present_in;
   logic          neg_ff, neg_in;
   logic [SW-1:0] mag_ff, mag_in;
   logic [GW-1:0] sgain_ff, sgain_in;
   logic          ugv_ff, ugv_in;
   logic [GW-1:0] ugain_ff, ugain_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          frames_seen_ff, frames_seen_in;

   always_comb begin
      drain_in   = drain_ff;
      last_in    = last_ff;
      hit_in     = hit_ff;
      present_in = present_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      sgain_in   = sgain_ff;
      ugv_in     = ugv_ff;
      ugain_in   = ugain_ff;
      addr_in    = addr_ff;
      if (cmd.capture) begin
         drain_in   = req_tuser == samacc_pkg::REQ_DRAIN;
         last_in    = req_tlast;
         hit_in     = hit_req;
         present_in = req_tdata[samacc_pkg::PRES_BIT];
         neg_in     = smp[SW-1];
         mag_in     = smp[SW-1] ? (~smp + 1'b1) : smp;
         sgain_in   = req_tdata[samacc_pkg::SG_LSB +: GW];
         ugv_in     = req_tdata[samacc_pkg::UGV_BIT];
         ugain_in   = req_tdata[samacc_pkg::UG_LSB +: GW];
         // park the address at zero when nothing is selected
         addr_in    = hit_req ? idx_wide[AW-1:0] : '0;
      end
   end

   always_comb begin
      window_in = csr_wr_en ? csr_wr_data : window_ff;
      frames_seen_in = frames_seen_ff;
      if (cmd.capture && (req_tuser == samacc_pkg::REQ_ACCUM)) begin
         frames_seen_in = 1'b1;
      end else if (cmd.load_rsp && last_ff) begin
         frames_seen_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- scaling
   logic [GW-1:0]  g2;
   logic [G2W-1:0] g12_ff, g12_in;
   logic [PW-1:0]  prod_ff, prod_in;
   logic [XW-1:0]  scaled_ff, scaled_in;

   assign g2 = ugv_ff ? ugain_ff : GW'(1);

   always_comb begin
      g12_in    = cmd.mul_gain ? (G2W'(sgain_ff) * G2W'(g2)) : g12_ff;
      prod_in   = cmd.mul_sample ? (PW'(mag_ff) * PW'(g12_ff)) : prod_ff;
      // times 32767 as a shift and subtract
      scaled_in = cmd.scale ? ({prod_ff, {SH{1'b0}}} - {{SH{1'b0}}, prod_ff})
                            : scaled_ff;
   end

   logic [MW-1:0] quotient;
   logic          div_done;

   samacc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (scaled_ff[XW-1:samacc_pkg::Q_FRAC]),
      .two_gains (ugv_ff),
      .quotient  (quotient),
      .done      (div_done)
   );

   // ---------------------------------------------------------------- mix store
   logic [MW-1:0] mem [DEPTH];
   logic [MW-1:0] rd_ff;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   logic [ACW-1:0] contrib;
   logic [ACW-1:0] sum;
   logic           ovf;
   logic [MW-1:0]  mix_result;

   always_comb begin
      // a quotient held at 16 bits still saturates whatever is stored
      contrib = neg_ff ? (~{2'b00, quotient} + 1'b1) : {2'b00, quotient};
      sum     = {{2{rd_ff[MW-1]}}, rd_ff} + contrib;
      ovf     = !(&sum[ACW-1:MW-1]) && (|sum[ACW-1:MW-1]);
      if (ovf) begin
         mix_result = sum[ACW-1] ? samacc_pkg::MIX_MIN : samacc_pkg::MIX_MAX;
      end else begin
         mix_result = sum[MW-1:0];
      end
   end

   assign clr_cnt_in = cmd.clear_step ? (clr_cnt_ff + 1'b1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      priority if (cmd.clear_step) begin
         mem[clr_cnt_ff] <= '0;
      end else if (cmd.acc_write) begin
         mem[addr_ff] <= mix_result;
      end else if (cmd.load_rsp && hit_ff) begin
         mem[addr_ff] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[addr_ff];
   end

   // ---------------------------------------------------------------- response
   logic          rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_user_ff, rsp_user_in;
   logic          rsp_last_ff, rsp_last_in;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = hit_ff ? rd_ff : '0;
         rsp_user_in  = frames_seen_ff;
         rsp_last_in  = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      drain_ff    <= drain_in;
      last_ff     <= last_in;
      hit_ff      <= hit_in;
      present_ff  <= present_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      sgain_ff    <= sgain_in;
      ugv_ff      <= ugv_in;
      ugain_ff    <= ugain_in;
      addr_ff     <= addr_in;
      g12_ff      <= g12_in;
      prod_ff     <= prod_in;
      scaled_ff   <= scaled_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         window_ff      <= samacc_pkg::WIN_RESET;
         frames_seen_ff <= 1'b0;
         clr_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_ff      <= window_in;
         frames_seen_ff <= frames_seen_in;
         clr_cnt_ff     <= clr_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      status.clear_last = clr_cnt_ff == LAST_ADDR;
      status.drain      = drain_ff;
      status.work       = !drain_ff && hit_ff && present_ff;
      status.div_done   = div_done;
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   // ---------------------------------------------------------------- checks
   `SAMACC_ASSERT_IMPL(a_acc_write_ready, clock, reset, cmd.acc_write, !drain_ff && hit_ff && present_ff && div_done, "store update without a finished scaled sample")
   `SAMACC_ASSERT_IMPL(a_rsp_no_overwrite, clock, reset, cmd.load_rsp && rsp_valid_ff, rsp_tready, "pending response overwritten")
   `SAMACC_ASSERT_IMPL(a_clear_quiet, clock, reset, cmd.clear_step, !rsp_valid_ff && !frames_seen_ff, "activity during clearing pass")
   `SAMACC_ASSERT_NEXT(a_div_restart, clock, reset, cmd.div_start, !div_done, "divider done flag survived a start")

endmodule

// ===== src/samacc_ctrl.sv =====
// ----------------------------------------------------------------------------
// samacc_ctrl
// Controller: sequences clearing, capture, scaling, store update and drain.
// ----------------------------------------------------------------------------
module samacc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  samacc_pkg::dp_status_type status,
   output samacc_pkg::ctrl_cmd_type  cmd
);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_DECODE = 4'd2;
   localparam logic [3:0] ST_MULS   = 4'd3;
   localparam logic [3:0] ST_SCALE  = 4'd4;
   localparam logic [3:0] ST_DIVS   = 4'd5;
   localparam logic [3:0] ST_DIVW   = 4'd6;
   localparam logic [3:0] ST_ACCW   = 4'd7;
   localparam logic [3:0] ST_DRSP   = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (status.drain) begin
               state_in = ST_DRSP;
            end else if (status.work) begin
               state_in = ST_MULS;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MULS:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DIVS;
         ST_DIVS:  state_in = ST_DIVW;
         ST_DIVW: begin
            if (status.div_done) begin
               state_in = ST_ACCW;
            end
         end
         ST_ACCW:  state_in = ST_IDLE;
         ST_DRSP: begin
            // hold until the response register frees up
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;

   always_comb begin
      cmd.capture    = (state_ff == ST_IDLE) && req_tvalid;
      cmd.clear_step = state_ff == ST_CLEAR;
      cmd.mul_gain   = state_ff == ST_DECODE;
      cmd.mul_sample = state_ff == ST_MULS;
      cmd.scale      = state_ff == ST_SCALE;
      cmd.div_start  = state_ff == ST_DIVS;
      cmd.acc_write  = state_ff == ST_ACCW;
      cmd.load_rsp   = (state_ff == ST_DRSP) && status.out_free;
   end

endmodule

// ===== src/saturating_audio_mix_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// saturating_audio_mix_accumulator_unit
// One item at a time. An accumulate that adds to the store goes from accept
// to the next accept through the gain and sample multiplies, the scale step
// and the reciprocal divide; other accumulates return to idle after decode.
// A drain's beat leaves from the response register the cycle after it is
// loaded; a drain waits longer while that register is stalled.
// After reset a clearing pass zeroes all MAX_FRAMES*CHANNELS store entries.
// ----------------------------------------------------------------------------
module saturating_audio_mix_accumulator_unit #(
   parameter int MAX_FRAMES = samacc_pkg::MAX_FRAMES_DEF,
   parameter int CHANNELS   = samacc_pkg::CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [samacc_pkg::WIN_W-1:0]      csr_wr_data,  // window_frames
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // frame_offset, channel, sample_value, sample_present, source_gain,
   // user_gain_valid, user_gain, zero fill
   input  logic [samacc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                              req_tuser,    // req_type
   input  logic                              req_tlast,    // drain_last
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [samacc_pkg::MIX_W-1:0]      rsp_tdata,    // mixed_sample
   output logic                              rsp_tuser,    // frames_mark
   output logic                              rsp_tlast     // last_out
);

   samacc_pkg::ctrl_cmd_type  cmd;
   samacc_pkg::dp_status_type status;

   samacc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   samacc_dp #(
      .MAX_FRAMES (MAX_FRAMES),
      .CHANNELS   (CHANNELS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ===== tb/saturating_audio_mix_accumulator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// saturating_audio_mix_accumulator_unit_tb
// Drives accumulate and drain beats into the mixer and keeps its own copy of
// the mix store and the has-frames mark. Every drain result is checked field
// by field against that copy. Both sides idle in random bursts but for the
// last phase. The window register is written after reset and rewritten
// between phases, once the previous phase has settled.
module saturating_audio_mix_accumulator_unit_tb;

   localparam int     STORE_DEPTH  = samacc_pkg::MAX_FRAMES_DEF * samacc_pkg::CHANNELS_DEF;
   localparam int     SETTLE_WAIT  = 60;       // outlasts an accumulate that adds to the store
   localparam int     PHASE_BEATS  = 225;
   localparam longint CYCLE_LIMIT  = 1000000;

   typedef struct packed {
      logic                            kind;
      logic [samacc_pkg::OFFSET_W-1:0] offset;
      logic                            channel;
      logic [samacc_pkg::SAMPLE_W-1:0] sample;
      logic                            present;
      logic [samacc_pkg::GAIN_W-1:0]   src_gain;
      logic                            usr_gain_on;
      logic [samacc_pkg::GAIN_W-1:0]   usr_gain;
      logic                            last;
   } mix_beat_type;

   typedef struct packed {
      logic [samacc_pkg::MIX_W-1:0] sample;
      logic                         frames;
      logic                         last;
   } mix_result_type;

   logic                              clock;
   logic                              reset       = 1'b1;
   logic                              csr_wr_en   = 1'b0;
   logic [samacc_pkg::WIN_W-1:0]      csr_wr_data = '0;
   logic                              req_tvalid  = 1'b0;
   logic                              req_tready;
   logic [samacc_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   logic                              req_tuser   = 1'b0;
   logic                              req_tlast   = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready  = 1'b0;
   logic [samacc_pkg::MIX_W-1:0]      rsp_tdata;
   logic                              rsp_tuser;
   logic                              rsp_tlast;

   // predicted mixer state
   logic [samacc_pkg::MIX_W-1:0] mix_model [STORE_DEPTH];
   logic                         model_frames = 1'b0;
   logic [samacc_pkg::WIN_W-1:0] model_window = samacc_pkg::WIN_RESET;

   mix_beat_type   beat_queue [$];
   mix_result_type pending_mixes [$];
   mix_beat_type   cur_beat;
   logic           req_accepted = 1'b0;
   bit             bursts_on = 1'b1;
   int             req_gap = 0;
   int             rsp_stall = 0;
   int             mismatch_count = 0;
   longint         cycle_count = 0;

   saturating_audio_mix_accumulator_unit uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      foreach (mix_model[i]) mix_model[i] = '0;
   end

   // sample * gain% [* gain%] at 16-bit full scale, truncated toward zero
   function automatic longint scaled_contribution(mix_beat_type b);
      longint          s;
      longint unsigned mag;
      longint unsigned den;
      longint unsigned q;
      s   = longint'($signed(b.sample));
      mag = (s < 0) ? -s : s;
      mag = mag * b.src_gain * longint'(samacc_pkg::MIX_MAX);
      den = longint'(samacc_pkg::PCT_DEN);
      if (b.usr_gain_on) begin
         mag = mag * b.usr_gain;
         den = longint'(samacc_pkg::PCT2_DEN);
      end
      q = (mag / den) >> samacc_pkg::Q_FRAC;
      return (s < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic void mix_predict(mix_beat_type b);
      int             off;
      int             span;
      int             idx;
      bit             hit;
      longint         acc;
      mix_result_type r;
      off  = int'($signed(b.offset));
      span = (model_window < samacc_pkg::MAX_FRAMES_DEF) ? int'(model_window)
                                                          : samacc_pkg::MAX_FRAMES_DEF;
      hit  = (off >= 0) && (off < span);
      idx  = off * samacc_pkg::CHANNELS_DEF + b.channel;
      if (b.kind == samacc_pkg::REQ_ACCUM) begin
         model_frames = 1'b1;
         if (hit && b.present) begin
            acc = longint'($signed(mix_model[idx])) + scaled_contribution(b);
            if (acc > longint'($signed(samacc_pkg::MIX_MAX)))
               acc = longint'($signed(samacc_pkg::MIX_MAX));
            if (acc < longint'($signed(samacc_pkg::MIX_MIN)))
               acc = longint'($signed(samacc_pkg::MIX_MIN));
            mix_model[idx] = acc[samacc_pkg::MIX_W-1:0];
         end
      end else begin
         r.sample = hit ? mix_model[idx] : '0;
         if (hit) mix_model[idx] = '0;
         r.frames = model_frames;
         r.last   = b.last;
         pending_mixes.push_back(r);
         // final drain reports the mark, then clears it
         if (b.last) model_frames = 1'b0;
      end
   endfunction

   function automatic mix_beat_type make_beat(logic kind, int off, int ch, int smp, logic pres,
                                              int sg, logic ugv, int ug, logic last);
      mix_beat_type b;
      b.kind        = kind;
      b.offset      = off[samacc_pkg::OFFSET_W-1:0];
      b.channel     = ch[0];
      b.sample      = smp[samacc_pkg::SAMPLE_W-1:0];
      b.present     = pres;
      b.src_gain    = sg[samacc_pkg::GAIN_W-1:0];
      b.usr_gain_on = ugv;
      b.usr_gain    = ug[samacc_pkg::GAIN_W-1:0];
      b.last        = last;
      return b;
   endfunction

   function automatic int rand_sample();
      int v;
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 4))
               0: return 'h7FFFFF;
               1: return -8388608;
               2: return 0;
               3: return -1;
               default: return 1;
            endcase
         end
         default: begin
            v = int'($urandom_range(0, 1 << 20));
            return $urandom_range(0, 1) ? -v : v;
         end
      endcase
   endfunction

   function automatic int rand_gain();
      case ($urandom_range(0, 5))
         0: return 100;
         1: return 0;
         2: return 1023;
         3: return 1000;
         4: return $urandom_range(50, 150);
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   // any beat at all, offsets biased toward the window edges
   function automatic mix_beat_type rand_noise(int span);
      int off;
      case ($urandom_range(0, 5))
         0: off = span - 1;
         1: off = span;
         2: off = -1;
         3: off = -4096;
         default: off = $urandom;
      endcase
      return make_beat(1'($urandom_range(0, 1)), off, $urandom_range(0, 1), rand_sample(),
                       1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                       1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                       1'($urandom_range(0, 1)));
   endfunction

   // mostly whole mixes: several sources over a few frames, then drain them
   task automatic gen_mix_phase(int count);
      int span;
      int added;
      int nframes;
      int start;
      int nsrc;
      span  = (model_window < samacc_pkg::MAX_FRAMES_DEF) ? int'(model_window)
                                                           : samacc_pkg::MAX_FRAMES_DEF;
      added = 0;
      while (added < count) begin
         if (span > 0 && $urandom_range(0, 3) != 0) begin
            nframes = $urandom_range(1, (span < 6) ? span : 6);
            start   = $urandom_range(0, span - nframes);
            nsrc    = $urandom_range(1, 4);
            for (int s = 0; s < nsrc; s++)
               for (int f = 0; f < nframes; f++)
                  for (int c = 0; c < samacc_pkg::CHANNELS_DEF; c++)
                     beat_queue.push_back(make_beat(samacc_pkg::REQ_ACCUM, start + f, c,
                        rand_sample(), $urandom_range(0, 9) != 0, rand_gain(),
                        1'($urandom_range(0, 1)), rand_gain(), 1'($urandom_range(0, 1))));
            for (int f = 0; f < nframes; f++)
               for (int c = 0; c < samacc_pkg::CHANNELS_DEF; c++)
                  beat_queue.push_back(make_beat(samacc_pkg::REQ_DRAIN, start + f, c,
                     $urandom, 1'b1, 0, 1'b0, 0,
                     (f == nframes - 1) && (c == samacc_pkg::CHANNELS_DEF - 1)));
            added += nframes * samacc_pkg::CHANNELS_DEF * (nsrc + 1);
         end else begin
            beat_queue.push_back(rand_noise(span));
            added++;
         end
      end
   endtask

   task automatic settle_idle();
      while (beat_queue.size() != 0 || req_tvalid || pending_mixes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_window(int value);
      @(negedge clock);
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= value[samacc_pkg::WIN_W-1:0];
      model_window = value[samacc_pkg::WIN_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // request driver: load a new beat once the held one is taken
   always @(negedge clock) begin : drive_req
      logic [samacc_pkg::REQ_DATA_W-1:0] word;
      mix_beat_type                      b;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (beat_queue.size() > 0) begin
            b    = beat_queue.pop_front();
            word = '0;
            word[samacc_pkg::OFF_LSB +: samacc_pkg::OFFSET_W] = b.offset;
            word[samacc_pkg::CH_BIT]                           = b.channel;
            word[samacc_pkg::SMP_LSB +: samacc_pkg::SAMPLE_W] = b.sample;
            word[samacc_pkg::PRES_BIT]                         = b.present;
            word[samacc_pkg::SG_LSB +: samacc_pkg::GAIN_W]    = b.src_gain;
            word[samacc_pkg::UGV_BIT]                          = b.usr_gain_on;
            word[samacc_pkg::UG_LSB +: samacc_pkg::GAIN_W]    = b.usr_gain;
            cur_beat   = b;
            req_tdata  <= word;
            req_tuser  <= b.kind;
            req_tlast  <= b.last;
            req_tvalid <= 1'b1;
            if (bursts_on && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 15);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready: stall in bursts
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
         if (bursts_on && $urandom_range(0, 11) == 0) rsp_stall = $urandom_range(1, 15);
      end
   end

   always @(posedge clock) begin : watch
      mix_result_type want;
      req_accepted <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_mixes.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, got data %0d user %b last %b",
                        $time, $signed(rsp_tdata), rsp_tuser, rsp_tlast);
               mismatch_count++;
            end else begin
               want = pending_mixes.pop_front();
               if (rsp_tdata !== want.sample) begin
                  $display("%0t: mixed_sample expected %0d got %0d",
                           $time, $signed(want.sample), $signed(rsp_tdata));
                  mismatch_count++;
               end
               if (rsp_tuser !== want.frames) begin
                  $display("%0t: frames mark expected %b got %b", $time, want.frames, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last_out expected %b got %b", $time, want.last, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) mix_predict(cur_beat);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int windows [8];
      windows = '{1, 0, 8191, 4095, 2, 37, 4096, 0};
      windows[7] = $urandom_range(3, 4094);
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      write_window(4096);

      // saturate up, then drain
      beat_queue.push_back(make_beat(samacc_pkg::REQ_ACCUM, 0, 0, 'h7FFFFF, 1'b1, 1023,
                                     1'b1, 1023, 1'b0));
      beat_queue.push_back(make_beat(samacc_pkg::REQ_ACCUM, 0, 0, 'h7FFFFF, 1'b1, 1023,
                                     1'b1, 1023, 1'b0));
      beat_queue.push_back(make_beat(samacc_pkg::REQ_DRAIN, 0, 0, 0, 1'b0, 0, 1'b0, 0, 1'b0));
      // most negative sample at the top of the window, saturate down
      beat_queue.push_back(make_beat(samacc_pkg::REQ_ACCUM, 4095, 1, -8388608, 1'b1, 100,
                                     1'b0, 0, 1'b1));
      beat_queue.push_back(make_beat(samacc_pkg::REQ_ACCUM, 4095, 1, -8388608, 1'b1, 100,
                                     1'b0, 0, 1'b0));
      beat_queue.push_back(make_beat(samacc_pkg::REQ_DRAIN, 4095, 1, 0, 1'b0, 0, 1'b0, 0,
                                     1'b0));
      // out-of-window offsets: dropped, drain returns zero
      beat_queue.push_back(make_beat(samacc_pkg::REQ_ACCUM, -1, 0, 'h7FFFFF, 1'b1, 1000,
                                     1'b0, 0, 1'b0));
      beat_queue.push_back(make_beat(samacc_pkg::REQ_ACCUM, -4096, 1, 'h7FFFFF, 1'b1, 1000,
                                     1'b1, 1000, 1'b0));
      beat_queue.push_back(make_beat(samacc_pkg::REQ_DRAIN, -1, 0, 0, 1'b0, 0, 1'b0, 0, 1'b0));
      // absent sample, zero gain, rounding toward zero
      beat_queue.push_back(make_beat(samacc_pkg::REQ_ACCUM, 1, 1, 'h7FFFFF, 1'b0, 1023,
                                     1'b1, 1023, 1'b0));
      beat_queue.push_back(make_beat(samacc_pkg::REQ_ACCUM, 1, 1, 'h7FFFFF, 1'b1, 0,
                                     1'b0, 1023, 1'b0));
      beat_queue.push_back(make_beat(samacc_pkg::REQ_ACCUM, 1, 1, 'h000100, 1'b1, 50,
                                     1'b1, 3, 1'b0));
      beat_queue.push_back(make_beat(samacc_pkg::REQ_ACCUM, 1, 1, -1, 1'b1, 1023,
                                     1'b1, 1023, 1'b0));
      beat_queue.push_back(make_beat(samacc_pkg::REQ_ACCUM, 1, 1, -300, 1'b1, 1023,
                                     1'b1, 1023, 1'b0));
      // final drain clears the mark; later drains report it low
      beat_queue.push_back(make_beat(samacc_pkg::REQ_DRAIN, 1, 1, 0, 1'b0, 0, 1'b0, 0, 1'b1));
      beat_queue.push_back(make_beat(samacc_pkg::REQ_DRAIN, 1, 1, 0, 1'b0, 0, 1'b0, 0, 1'b0));
      beat_queue.push_back(make_beat(samacc_pkg::REQ_DRAIN, 0, 1, 0, 1'b0, 0, 1'b0, 0, 1'b1));
      // user gain ignored when not valid, opposite signs cancel
      beat_queue.push_back(make_beat(samacc_pkg::REQ_ACCUM, 2, 0, 'h400000, 1'b1, 100,
                                     1'b0, 1023, 1'b0));
      beat_queue.push_back(make_beat(samacc_pkg::REQ_ACCUM, 2, 0, -4194304, 1'b1, 200,
                                     1'b1, 50, 1'b0));
      beat_queue.push_back(make_beat(samacc_pkg::REQ_DRAIN, 2, 0, 0, 1'b0, 0, 1'b0, 0, 1'b1));
      settle_idle();

      foreach (windows[i]) begin
         // last phase runs without idling
         bursts_on = (i != 7);
         write_window(windows[i]);
         gen_mix_phase(PHASE_BEATS);
         settle_idle();
      end

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
